[rtl/acf_pkg.sv]
// Shared types, widths and arithmetic helpers for the altitude fusion unit.
package acf_pkg;

	localparam int GREF_W  = 23;
	localparam int GAIN_W  = 17;
	localparam int DIFF_W  = 25;
	localparam int ACCEL_W = 42;
	localparam int MUL_A_W = 42;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int RND_W   = PROD_W - 16;
	localparam int SUM_W   = RND_W + 1;
	localparam int CFG_IDX_W = 3;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED       = 3'd0,
		REG_GRAVITY_REF   = 3'd1,
		REG_ACCEL_SCALE   = 3'd2,
		REG_POSITION_GAIN = 3'd3,
		REG_VELOCITY_GAIN = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_MUL_ACC,
		OP_RND_ACC,
		OP_MUL_VDT,
		OP_UPD_VEL,
		OP_MUL_PDT,
		OP_UPD_ALT,
		OP_MUL_PG,
		OP_COR_ALT,
		OP_MUL_VG,
		OP_COR_VEL
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_in;
		logic load_out;
		logic applied;
	} cmd_t;

	typedef struct packed {
		logic restart;
		logic step_zero;
	} status_t;

	typedef struct packed {
		logic              enabled;
		logic [GREF_W-1:0] gravity_reference;
		logic [31:0]       accel_scale;
		logic [GAIN_W-1:0] position_gain;
		logic [GAIN_W-1:0] velocity_gain;
	} cfg_t;

	// Round half up and drop 16 fraction bits.
	function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + $signed({{(PROD_W-16){1'b0}}, 16'h8000});
		return t[PROD_W-1:16];
	endfunction

	// Add a rounded product to a 32-bit state value and saturate.
	function automatic logic signed [31:0] add_sat(input logic signed [31:0] s,
		input logic signed [PROD_W-1:0] p);
		logic signed [RND_W-1:0] r;
		logic signed [SUM_W-1:0] v;
		r = rnd16(p);
		v = $signed({{(SUM_W-32){s[31]}}, s}) + $signed({r[RND_W-1], r});
		if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
			return v[31:0];
		end
		return v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

endpackage

[rtl/acf_regs.sv]
// Configuration register file of the altitude fusion unit.
module acf_regs
	import acf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled           <= 1'b0;
			cfg_q.gravity_reference <= 23'd4194304;
			cfg_q.accel_scale       <= 32'd2570753;
			cfg_q.position_gain     <= 17'd26214;
			cfg_q.velocity_gain     <= 17'd13107;
		end else if (cfg_valid) begin
			// drop writes to unknown indexes
			unique case (cfg_index)
				REG_ENABLED:       cfg_q.enabled           <= cfg_data[0];
				REG_GRAVITY_REF:   cfg_q.gravity_reference <= cfg_data[GREF_W-1:0];
				REG_ACCEL_SCALE:   cfg_q.accel_scale       <= cfg_data;
				REG_POSITION_GAIN: cfg_q.position_gain     <= cfg_data[GAIN_W-1:0];
				REG_VELOCITY_GAIN: cfg_q.velocity_gain     <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/acf_ctrl.sv]
// Sequencing state machine of the altitude fusion unit.
module acf_ctrl
	import acf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  logic    enabled,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_ACC,
		S_RND_ACC,
		S_MUL_VDT,
		S_UPD_VEL,
		S_MUL_PDT,
		S_UPD_ALT,
		S_MUL_PG,
		S_COR_ALT,
		S_MUL_VG,
		S_COR_VEL,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   applied_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op       = OP_NONE;
		cmd.load_in  = 1'b0;
		cmd.load_out = 1'b0;
		cmd.applied  = applied_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid && sts.restart) begin
					cmd.op = OP_CLEAR;
				end
			end
			S_MUL_ACC: cmd.op = OP_MUL_ACC;
			S_RND_ACC: cmd.op = OP_RND_ACC;
			S_MUL_VDT: cmd.op = OP_MUL_VDT;
			S_UPD_VEL: cmd.op = OP_UPD_VEL;
			S_MUL_PDT: cmd.op = OP_MUL_PDT;
			S_UPD_ALT: cmd.op = OP_UPD_ALT;
			S_MUL_PG:  cmd.op = OP_MUL_PG;
			S_COR_ALT: cmd.op = OP_COR_ALT;
			S_MUL_VG:  cmd.op = OP_MUL_VG;
			S_COR_VEL: cmd.op = OP_COR_VEL;
			S_FINISH:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			applied_q   <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (sts.restart) begin
							applied_q <= 1'b1;
							state_q   <= S_FINISH;
						end else if (enabled && !sts.step_zero) begin
							applied_q <= 1'b1;
							state_q   <= S_MUL_ACC;
						end else begin
							applied_q <= 1'b0;
							state_q   <= S_FINISH;
						end
					end
				end
				S_MUL_ACC: state_q <= S_RND_ACC;
				S_RND_ACC: state_q <= S_MUL_VDT;
				S_MUL_VDT: state_q <= S_UPD_VEL;
				S_UPD_VEL: state_q <= S_MUL_PDT;
				S_MUL_PDT: state_q <= S_UPD_ALT;
				S_UPD_ALT: state_q <= S_MUL_PG;
				S_MUL_PG:  state_q <= S_COR_ALT;
				S_COR_ALT: state_q <= S_MUL_VG;
				S_MUL_VG:  state_q <= S_COR_VEL;
				S_COR_VEL: state_q <= S_FINISH;
				S_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/acf_datapath.sv]
// Datapath of the altitude fusion unit: one shared multiplier and the estimate registers.
module acf_datapath
	import acf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            sts,
	input  cfg_t               cfg,
	input  logic               req_type,
	input  logic signed [15:0] raw_accel_z,
	input  logic signed [31:0] baro_altitude,
	input  logic [15:0]        time_step,
	output logic [30:0]        fused_altitude,
	output logic signed [31:0] vertical_velocity,
	output logic               applied
);

	localparam int ACC_SH = 40 - FRAC_BITS;

	logic signed [15:0]         raw_q;
	logic signed [31:0]         baro_q;
	logic [15:0]                dt_q;
	logic signed [31:0]         alt_q;
	logic signed [31:0]         vel_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACCEL_W-1:0]  accel_q;
	logic signed [32:0]         err_q;
	logic [30:0]                alt_out_q;
	logic signed [31:0]         vel_out_q;
	logic                       applied_q;

	logic signed [DIFF_W-1:0]   diff;
	logic signed [32:0]         err;
	logic [GAIN_W-1:0]          gp_c;
	logic [GAIN_W-1:0]          gv_c;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   product;
	logic signed [PROD_W-1:0]   acc_t;
	logic signed [PROD_W-1:0]   acc_sh;
	logic signed [31:0]         alt_cor;

	assign sts.restart   = req_type;
	assign sts.step_zero = (time_step == 16'd0);

	assign diff = $signed({raw_q[15], raw_q, 8'h00}) - $signed({2'b00, cfg.gravity_reference});
	assign err  = $signed({baro_q[31], baro_q}) - $signed({alt_q[31], alt_q});
	assign gp_c = (cfg.position_gain > GAIN_ONE) ? GAIN_ONE : cfg.position_gain;
	assign gv_c = (cfg.velocity_gain > GAIN_ONE) ? GAIN_ONE : cfg.velocity_gain;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_ACC: begin
				mul_a = $signed({{(MUL_A_W-32){1'b0}}, cfg.accel_scale});
				mul_b = diff;
			end
			OP_MUL_VDT: begin
				mul_a = accel_q;
				mul_b = $signed({{(MUL_B_W-16){1'b0}}, dt_q});
			end
			OP_MUL_PDT: begin
				mul_a = $signed({{(MUL_A_W-32){vel_q[31]}}, vel_q});
				mul_b = $signed({{(MUL_B_W-16){1'b0}}, dt_q});
			end
			OP_MUL_PG: begin
				mul_a = $signed({{(MUL_A_W-33){err[32]}}, err});
				mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gp_c});
			end
			OP_MUL_VG: begin
				mul_a = $signed({{(MUL_A_W-33){err_q[32]}}, err_q});
				mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gv_c});
			end
			default: ;
		endcase
	end

	assign product = mul_a * mul_b;

	// Rounding shift that brings the scaled acceleration to the state format.
	assign acc_t   = prod_q + $signed(PROD_W'(1) << (ACC_SH - 1));
	assign acc_sh  = acc_t >>> ACC_SH;
	assign alt_cor = add_sat(alt_q, prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q <= '0;
			vel_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR: begin
					alt_q <= '0;
					vel_q <= '0;
				end
				OP_UPD_VEL: vel_q <= add_sat(vel_q, prod_q);
				OP_UPD_ALT: alt_q <= add_sat(alt_q, prod_q);
				OP_COR_ALT: alt_q <= alt_cor[31] ? 32'sd0 : alt_cor;
				OP_COR_VEL: vel_q <= add_sat(vel_q, prod_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q  <= raw_accel_z;
			baro_q <= baro_altitude;
			dt_q   <= time_step;
		end
		if (cmd.op == OP_MUL_ACC || cmd.op == OP_MUL_VDT || cmd.op == OP_MUL_PDT
			|| cmd.op == OP_MUL_PG || cmd.op == OP_MUL_VG) begin
			prod_q <= product;
		end
		if (cmd.op == OP_RND_ACC) begin
			accel_q <= acc_sh[ACCEL_W-1:0];
		end
		// keep the barometer error for the velocity correction
		if (cmd.op == OP_MUL_PG) begin
			err_q <= err;
		end
		if (cmd.load_out) begin
			alt_out_q <= alt_q[30:0];
			vel_out_q <= vel_q;
			applied_q <= cmd.applied;
		end
	end

	assign fused_altitude    = alt_out_q;
	assign vertical_velocity = vel_out_q;
	assign applied           = applied_q;

endmodule

[rtl/altitude_complementary_fusion_unit.sv]
// Top level of the altitude fusion unit: registers, controller and datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | in_valid / in_stall | req_type, raw_accel_z, baro_altitude, time_step
//  output   | out_valid/out_stall | fused_altitude, vertical_velocity, applied
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A fuse item goes from transfer to the next free input slot via the idle state, ten
// steps of the shared 42x25 multiplier sequence (five products, each followed by a
// rounding or update step) and the finish state that loads the output register. A
// restart or skipped item goes straight from idle to finish. The output register holds
// one result, so an item finishing while the previous result is still stalled waits in
// its last step. Reset clears the estimates and all valids, the config to its defaults.
module altitude_complementary_fusion_unit
	import acf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic signed [15:0]   raw_accel_z,
	input  logic signed [31:0]   baro_altitude,
	input  logic [15:0]          time_step,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [30:0]          fused_altitude,
	output logic signed [31:0]   vertical_velocity,
	output logic                 applied,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t sts;

	acf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	acf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.enabled   (cfg.enabled),
		.sts       (sts),
		.cmd       (cmd)
	);

	acf_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg               (cfg),
		.req_type          (req_type),
		.raw_accel_z       (raw_accel_z),
		.baro_altitude     (baro_altitude),
		.time_step         (time_step),
		.fused_altitude    (fused_altitude),
		.vertical_velocity (vertical_velocity),
		.applied           (applied)
	);

endmodule

[rtl/acf_checker.sv]
// Port-level checks of the altitude fusion unit and their bind.
module acf_checker
	import acf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 req_type,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [30:0]          fused_altitude,
	input logic signed [31:0]   vertical_velocity,
	input logic                 applied
);

	// The unit works on one item at a time.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transfer");

	// A result appears only from a busy unit.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// A restart into a free output passes through the finish state and then shows zeros.
	a_restart_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type && !out_valid |=> ##1
		out_valid && applied && fused_altitude == 31'd0 && vertical_velocity == 32'sd0)
		else $error("restart result wrong or late");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fused_altitude)
		&& $stable(vertical_velocity) && $stable(applied))
		else $error("stalled result changed");

endmodule

bind altitude_complementary_fusion_unit acf_checker u_acf_checker (.*);

[bench/tb.sv]
// Self-checking bench for the altitude fusion unit: directed table plus random sample streams.
`timescale 1ns / 100ps

module tb;
	import acf_pkg::*;

	localparam logic REQ_FUSE    = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	localparam logic [31:0] GRAVITY_DEFAULT  = 32'd4194304;
	localparam logic [31:0] SCALE_DEFAULT    = 32'd2570753;
	localparam logic [31:0] POS_GAIN_DEFAULT = 32'd26214;
	localparam logic [31:0] VEL_GAIN_DEFAULT = 32'd13107;

	localparam int          SETTLE_CYCLES   = 16;
	localparam int          PHASES          = 13;
	localparam int          ITEMS_PER_PHASE = 100;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam longint      S32_MAX         = 64'sd2147483647;
	localparam longint      S32_MIN         = -64'sd2147483648;

	typedef struct packed {
		logic [30:0]        alt;
		logic signed [31:0] vel;
		logic               applied;
	} fusion_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               req;
		logic signed [15:0] accel;
		logic signed [31:0] baro;
		logic [15:0]        dt;
		reg_idx_t           reg_sel;
		logic [31:0]        reg_val;
		logic               typed;
		logic [30:0]        want_alt;
		logic signed [31:0] want_vel;
		logic               want_applied;
	} plan_row_t;

	localparam int PLAN_LEN = 37;

	// Typed expectations only where the answer is obvious: reset state, restarts, skips and a fuse at rest.
	plan_row_t plan [PLAN_LEN] = '{
		'{ROW_ITEM, REQ_FUSE, 16'h7FFF, 32'h7FFF_FFFF, 16'hFFFF, REG_ENABLED, '0, 1'b1, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_RESTART, 16'h8000, 32'h8000_0000, 16'hFFFF, REG_ENABLED, '0,
			1'b1, '0, '0, 1'b1},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_ENABLED, 32'd1, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h8000, 32'h8000_0000, 16'h0000, REG_ENABLED, '0,
			1'b1, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'd16384, 32'h0, 16'd3277, REG_ENABLED, '0, 1'b1, '0, '0, 1'b1},
		'{ROW_ITEM, REQ_FUSE, 16'h7FFF, 32'h7FFF_FFFF, 16'hFFFF, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h7FFF, 32'h7FFF_FFFF, 16'hFFFF, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h8000, 32'h8000_0000, 16'hFFFF, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h0000, 32'h0064_0000, 16'h0001, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_RESTART, 16'h7FFF, 32'h7FFF_FFFF, 16'h0000, REG_ENABLED, '0,
			1'b1, '0, '0, 1'b1},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_GRAVITY_REF, 32'd0, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_ACCEL_SCALE, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_POSITION_GAIN, 32'h0001_FFFF, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_VELOCITY_GAIN, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h7FFF, 32'h7FFF_FFFF, 16'hFFFF, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h8000, 32'h8000_0000, 16'hFFFF, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'hFFFF, 32'hFFFF_FFFF, 16'h8000, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_GRAVITY_REF, 32'h007F_FFFF, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_ACCEL_SCALE, 32'd0, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_POSITION_GAIN, 32'd0, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_VELOCITY_GAIN, 32'd0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h7FFF, 32'h7FFF_FFFF, 16'hFFFF, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h8000, 32'h1234_5678, 16'hFFFF, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_ACCEL_SCALE, 32'd1, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_POSITION_GAIN, 32'd65536, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_VELOCITY_GAIN, 32'd65536, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h5555, 32'hAAAA_AAAA, 16'h5555, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'hAAAA, 32'h5555_5555, 16'hAAAA, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_ENABLED, 32'hFFFF_FFFE, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'h04D2, 32'h0000_162E, 16'h0064, REG_ENABLED, '0, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_RESTART, 16'h0000, 32'h0, 16'h0000, REG_ENABLED, '0, 1'b1, '0, '0, 1'b1},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_ENABLED, 32'd1, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_GRAVITY_REF, GRAVITY_DEFAULT, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_ACCEL_SCALE, SCALE_DEFAULT, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_POSITION_GAIN, POS_GAIN_DEFAULT, 1'b0, '0, '0, 1'b0},
		'{ROW_CFG, REQ_FUSE, '0, '0, '0, REG_VELOCITY_GAIN, VEL_GAIN_DEFAULT, 1'b0, '0, '0, 1'b0},
		'{ROW_ITEM, REQ_FUSE, 16'd16384, 32'h000A_0000, 16'd3277, REG_ENABLED, '0,
			1'b0, '0, '0, 1'b0}
	};

	logic                 clk;
	logic                 arst_n            = 1'b0;
	logic                 in_valid          = 1'b0;
	logic                 in_stall;
	logic                 req_type          = 1'b0;
	logic signed [15:0]   raw_accel_z       = '0;
	logic signed [31:0]   baro_altitude     = '0;
	logic [15:0]          time_step         = '0;
	logic                 out_valid;
	logic                 out_stall         = 1'b0;
	logic [30:0]          fused_altitude;
	logic signed [31:0]   vertical_velocity;
	logic                 applied;
	logic                 cfg_valid         = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index         = '0;
	logic [31:0]          cfg_data          = '0;

	// Predictor copy of the block's registers and estimates.
	logic               set_enabled  = 1'b0;
	logic [22:0]        set_gravity  = 23'd4194304;
	logic [31:0]        set_scale    = 32'd2570753;
	logic [16:0]        set_pos_gain = 17'd26214;
	logic [16:0]        set_vel_gain = 17'd13107;
	logic signed [31:0] est_altitude = '0;
	logic signed [31:0] est_velocity = '0;

	fusion_result_t pending_results[$];

	bit          no_idle        = 1'b0;
	int          hold_left      = 0;
	int          mismatches     = 0;
	int          requests_sent  = 0;
	int          restarts_sent  = 0;
	int          skipped_fuses  = 0;
	int          results_seen   = 0;
	int          reg_writes     = 0;
	int unsigned cycle_count    = 0;

	altitude_complementary_fusion_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.raw_accel_z       (raw_accel_z),
		.baro_altitude     (baro_altitude),
		.time_step         (time_step),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.fused_altitude    (fused_altitude),
		.vertical_velocity (vertical_velocity),
		.applied           (applied),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Round half up, then drop sh fraction bits.
	function automatic longint drop_frac(input longint v, input int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > S32_MAX) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < S32_MIN) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Advance the estimates by one request and return the result it should produce.
	function automatic fusion_result_t predict_fusion(input logic req,
		input logic signed [15:0] accel, input logic signed [31:0] baro, input logic [15:0] dt);
		fusion_result_t     res;
		longint             diff;
		longint             lin_acc;
		longint             err;
		longint             pg;
		longint             vg;
		logic signed [31:0] vel;
		logic signed [31:0] alt;
		res.applied = 1'b0;
		if (req == REQ_RESTART) begin
			est_altitude = '0;
			est_velocity = '0;
			res.applied = 1'b1;
		end else if (set_enabled && dt != 16'd0) begin
			diff = longint'(accel) * 256 - longint'(set_gravity);
			lin_acc = drop_frac(diff * longint'(set_scale), 24);
			vel = clip32(longint'(est_velocity) + drop_frac(lin_acc * longint'(dt), 16));
			alt = clip32(longint'(est_altitude) + drop_frac(longint'(vel) * longint'(dt), 16));
			err = longint'(baro) - longint'(alt);
			pg = (set_pos_gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(set_pos_gain);
			vg = (set_vel_gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(set_vel_gain);
			alt = clip32(longint'(alt) + drop_frac(pg * err, 16));
			vel = clip32(longint'(vel) + drop_frac(vg * err, 16));
			if (alt < 0) begin
				alt = '0;
			end
			est_altitude = alt;
			est_velocity = vel;
			res.applied = 1'b1;
		end
		res.alt = est_altitude[30:0];
		res.vel = est_velocity;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at result %0d: got %0d, expected %0d",
			what, results_seen, got, want);
		mismatches++;
	endtask

	// Hold valid for back-to-back requests; drop it only when a gap is drawn.
	task automatic send_item(input logic req, input logic signed [15:0] accel,
		input logic signed [31:0] baro, input logic [15:0] dt, input logic typed,
		input fusion_result_t want);
		int             gap;
		fusion_result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		raw_accel_z <= accel;
		baro_altitude <= baro;
		time_step <= dt;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = predict_fusion(req, accel, baro, dt);
		pending_results.push_back(typed ? want : predicted);
		requests_sent++;
		if (req == REQ_RESTART) begin
			restarts_sent++;
		end else if (!predicted.applied) begin
			skipped_fuses++;
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write of a group.
	task automatic write_reg(input reg_idx_t sel, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (sel)
			REG_ENABLED:       set_enabled = value[0];
			REG_GRAVITY_REF:   set_gravity = value[22:0];
			REG_ACCEL_SCALE:   set_scale = value;
			REG_POSITION_GAIN: set_pos_gain = value[16:0];
			REG_VELOCITY_GAIN: set_vel_gain = value[16:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		fusion_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected transfer", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (fused_altitude !== want.alt) begin
						report_mismatch("fused_altitude", fused_altitude, want.alt);
					end
					if (vertical_velocity !== want.vel) begin
						report_mismatch("vertical_velocity", vertical_velocity, want.vel);
					end
					if (applied !== want.applied) begin
						report_mismatch("applied", applied, want.applied);
					end
				end
				results_seen++;
				hold_left = no_idle ? 0 : $urandom_range(0, 3);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0);
		end
	end

	initial begin : stimulus
		fusion_result_t     want;
		logic               cfg_open;
		logic               req;
		logic signed [15:0] accel;
		logic signed [31:0] baro;
		logic [15:0]        dt;
		logic [31:0]        noise;
		int                 near;
		int                 phase;
		int                 n;
		cfg_open = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < PLAN_LEN; n++) begin
			if (plan[n].kind == ROW_CFG) begin
				if (!cfg_open) begin
					drain_results();
					cfg_open = 1'b1;
				end
				write_reg(plan[n].reg_sel, plan[n].reg_val);
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				want.alt = plan[n].want_alt;
				want.vel = plan[n].want_vel;
				want.applied = plan[n].want_applied;
				send_item(plan[n].req, plan[n].accel, plan[n].baro, plan[n].dt,
					plan[n].typed, want);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			no_idle = (phase % 4 == 2);
			noise = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
			write_reg(REG_ENABLED, {noise[31:1], ($urandom_range(0, 7) != 0)});
			write_reg(REG_GRAVITY_REF, ($urandom_range(0, 3) == 0) ? $urandom
				: GRAVITY_DEFAULT + $urandom_range(0, 131072) - 32'd65536);
			write_reg(REG_ACCEL_SCALE, ($urandom_range(0, 3) == 0) ? $urandom
				: SCALE_DEFAULT + $urandom_range(0, 1000000) - 32'd500000);
			write_reg(REG_POSITION_GAIN,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536));
			write_reg(REG_VELOCITY_GAIN,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536));
			cfg_valid <= 1'b0;

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				req = ($urandom_range(0, 39) == 0) ? REQ_RESTART : REQ_FUSE;
				// Mostly samples near rest and baro near the estimate, so the filter tracks.
				if ($urandom_range(0, 3) == 0) begin
					accel = 16'($urandom);
				end else begin
					near = int'(set_gravity >> 8) + int'($urandom_range(0, 8000)) - 4000;
					if (near > 32767) begin
						near = 32767;
					end
					accel = 16'(near);
				end
				if ($urandom_range(0, 3) == 0) begin
					baro = $urandom;
				end else begin
					baro = clip32(longint'(est_altitude) + longint'($urandom_range(0, 2097152))
						- 64'sd1048576);
				end
				case ($urandom_range(0, 9))
					0:       dt = 16'd0;
					1, 2:    dt = 16'($urandom);
					default: dt = 16'($urandom_range(1000, 6000));
				endcase
				send_item(req, accel, baro, dt, 1'b0, '0);
				if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 63) == 0) begin
					drain_results();
				end
			end
		end

		drain_results();
		$display("covered %0d requests: %0d restarts, %0d skipped fuses, %0d results checked",
			requests_sent, restarts_sent, skipped_fuses, results_seen);
		$display("covered %0d register writes across %0d random settings, %0d mismatches",
			reg_writes, PHASES, mismatches);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
